// ----- sv/ats_pkg.sv -----
// ats_pkg: types and constants shared by the alarm table scheduler files.
// No dependencies.
package ats_pkg;

    localparam int FIELD_TIME_W = 62;
    localparam int HANDLE_W     = 8;
    localparam int MAX_RESULTS  = 64;
    localparam int CNT_W        = $clog2(MAX_RESULTS + 1);

    typedef enum logic [1:0] {
        KIND_SET_ONE = 2'd0,
        KIND_SET_PER = 2'd1,
        KIND_CANCEL  = 2'd2,
        KIND_TICK    = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        STAT_OK         = 3'd0,
        STAT_BAD_PERIOD = 3'd1,
        STAT_FULL       = 3'd2,
        STAT_FIRED      = 3'd3,
        STAT_NONE       = 3'd4
    } status_t;

    typedef struct packed {
        kind_t                   kind;
        logic [HANDLE_W-1:0]     alarm_handle;
        logic [FIELD_TIME_W-1:0] time_value;
        logic [FIELD_TIME_W-1:0] period;
        logic [FIELD_TIME_W-1:0] now;
    } in_item_t;

    typedef struct packed {
        status_t             status;
        logic [HANDLE_W-1:0] fired_handle;
        logic                last;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV_SET,
        ST_DROP_RD,
        ST_DROP_CK,
        ST_PLACE,
        ST_TICK_RD,
        ST_TICK_CK,
        ST_TICK_DIV,
        ST_TICK_END
    } state_t;

endpackage

// ----- sv/ats_ram.sv -----
// ats_ram: generic single write port RAM with registered read.
// No dependencies.
module ats_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/ats_rem_div.sv -----
// ats_rem_div: restoring divider, one quotient bit per cycle, remainder only.
// No dependencies.
module ats_rem_div #(
    parameter int WIDTH = 62
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic             done,
    output logic [WIDTH-1:0] remainder
);

    localparam int SW = $clog2(WIDTH + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [SW-1:0]    step_reg, step_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] dq_reg, dq_next;
    logic [WIDTH:0]   trial;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        dq_next   = dq_reg;
        trial     = {rem_reg, dq_reg[WIDTH-1]};
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            dq_next   = dividend;
        end else if (busy_reg) begin
            if (trial >= {1'b0, divisor}) begin
                rem_next = WIDTH'(trial - {1'b0, divisor});
            end else begin
                rem_next = trial[WIDTH-1:0];
            end
            dq_next   = {dq_reg[WIDTH-2:0], 1'b0};
            step_next = step_reg + 1'b1;
            if (step_reg == SW'(WIDTH - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ----- sv/alarm_table_scheduler_core.sv -----
// alarm_table_scheduler_core: alarm slot table with set, cancel and tick sequencer.
// Depends on ats_pkg, ats_ram, ats_rem_div.
//
// channel | ports                    | payload
// input   | s_valid s_ready s_data   | in_item_t
// result  | m_valid m_ready m_data   | out_item_t
//
// One item at a time; s_ready is high only between items.
// Set/cancel: one read and check pass over the slots, plus a divider run for a periodic start in the past.
// Tick: one read and check pass over the slots, plus a divider run per due periodic alarm.
// Reset clears all slot used bits at once; no clearing pass.
// A stalled result register holds the sequencer at its next result.
module alarm_table_scheduler_core
    import ats_pkg::*;
#(
    parameter int ALARM_SLOTS  = 64,
    parameter int HANDLE_COUNT = 256,
    parameter int TIME_BITS    = 62
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam int TB    = TIME_BITS;
    localparam int IDX_W = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;
    localparam int IW1   = IDX_W + 1;
    localparam int WW    = HANDLE_W + TB + 1 + TB;

    state_t state_reg, state_next;
    logic [IW1-1:0]      idx_reg, idx_next;
    logic                free_found_reg, free_found_next;
    logic [IDX_W-1:0]    free_idx_reg, free_idx_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [HANDLE_W-1:0] pend_handle_reg, pend_handle_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [ALARM_SLOTS-1:0] used_reg, used_next;
    logic [TB:0]         fire_reg, fire_next;
    kind_t               kind_reg;
    logic [HANDLE_W-1:0] h_reg;
    logic [TB-1:0]       tv_reg, per_reg, now_reg;
    out_item_t           out_reg, out_item;
    logic                out_valid_reg;
    logic                emit, can_emit;

    logic [HANDLE_W-1:0] hmap [HANDLE_COUNT > 0 ? 256 : 256];

    logic            ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [WW-1:0]   ram_wdata, ram_rdata;
    logic [HANDLE_W-1:0] rd_owner;
    logic [TB:0]     rd_fire;
    logic [TB-1:0]   rd_rep;

    logic            div_start, div_done;
    logic [TB-1:0]   div_dividend, div_divisor, div_rem;
    logic [TB:0]     adv;
    logic [IDX_W-1:0] idx;
    logic            drop, due;
    logic            accept;

    for (genvar g = 0; g < 256; g++) begin : g_hmap
        assign hmap[g] = HANDLE_W'(g % HANDLE_COUNT);
    end

    assign idx      = idx_reg[IDX_W-1:0];
    assign rd_owner = ram_rdata[WW-1 -: HANDLE_W];
    assign rd_fire  = ram_rdata[TB +: TB + 1];
    assign rd_rep   = ram_rdata[TB-1:0];
    assign can_emit = !out_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;

    ats_ram #(
        .WIDTH (WW),
        .DEPTH (ALARM_SLOTS),
        .AW    (IDX_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx),
        .rdata (ram_rdata)
    );

    always_comb begin
        if (state_reg == ST_PREP || state_reg == ST_DIV_SET) begin
            div_dividend = now_reg - tv_reg;
            div_divisor  = per_reg;
        end else begin
            div_dividend = now_reg - rd_fire[TB-1:0];
            div_divisor  = rd_rep;
        end
    end

    ats_rem_div #(
        .WIDTH (TB)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .remainder (div_rem)
    );

    // first fire time on the period grid after now: now - rem + period
    assign adv  = {1'b0, now_reg} - {1'b0, div_rem} + {1'b0, div_divisor};
    assign drop = used_reg[idx] && (rd_owner == h_reg);
    assign due  = used_reg[idx] && (rd_fire <= {1'b0, now_reg});

    always_comb begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        pend_valid_next  = pend_valid_reg;
        pend_handle_next = pend_handle_reg;
        cnt_next         = cnt_reg;
        used_next        = used_reg;
        fire_next        = fire_reg;
        s_ready          = 1'b0;
        emit             = 1'b0;
        out_item         = '{status: STAT_OK, fired_handle: '0, last: 1'b1};
        ram_we           = 1'b0;
        ram_waddr        = idx;
        ram_wdata        = {rd_owner, adv, rd_rep};
        div_start        = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next      = ST_PREP;
                    idx_next        = '0;
                    free_found_next = 1'b0;
                    pend_valid_next = 1'b0;
                    cnt_next        = '0;
                end
            end
            ST_PREP: begin
                unique case (kind_reg)
                    KIND_SET_ONE: begin
                        fire_next  = {1'b0, now_reg} + {1'b0, tv_reg};
                        state_next = ST_DROP_RD;
                    end
                    KIND_SET_PER: begin
                        if (per_reg == '0) begin
                            if (can_emit) begin
                                emit       = 1'b1;
                                out_item   = '{status: STAT_BAD_PERIOD,
                                               fired_handle: '0, last: 1'b1};
                                state_next = ST_IDLE;
                            end
                        end else if (tv_reg < now_reg) begin
                            div_start  = 1'b1;
                            state_next = ST_DIV_SET;
                        end else begin
                            fire_next  = {1'b0, tv_reg};
                            state_next = ST_DROP_RD;
                        end
                    end
                    KIND_CANCEL: state_next = ST_DROP_RD;
                    KIND_TICK:   state_next = ST_TICK_RD;
                    default:     state_next = ST_IDLE;
                endcase
            end
            ST_DIV_SET: begin
                if (div_done) begin
                    fire_next  = adv;
                    state_next = ST_DROP_RD;
                end
            end
            ST_DROP_RD: state_next = ST_DROP_CK;
            ST_DROP_CK: begin
                if (drop) begin
                    used_next[idx] = 1'b0;
                end
                if ((!used_reg[idx] || drop) && !free_found_reg) begin
                    free_found_next = 1'b1;
                    free_idx_next   = idx;
                end
                if (idx_reg == IW1'(ALARM_SLOTS - 1)) begin
                    state_next = ST_PLACE;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_DROP_RD;
                end
            end
            ST_PLACE: begin
                if (can_emit) begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                    if (kind_reg != KIND_CANCEL) begin
                        if (free_found_reg) begin
                            ram_we    = 1'b1;
                            ram_waddr = free_idx_reg;
                            ram_wdata = {h_reg, fire_reg,
                                         (kind_reg == KIND_SET_PER) ? per_reg : TB'(0)};
                            used_next[free_idx_reg] = 1'b1;
                        end else begin
                            out_item.status = STAT_FULL;
                        end
                    end
                end
            end
            ST_TICK_RD: begin
                if (idx_reg == IW1'(ALARM_SLOTS) || cnt_reg == CNT_W'(MAX_RESULTS)) begin
                    state_next = ST_TICK_END;
                end else begin
                    state_next = ST_TICK_CK;
                end
            end
            ST_TICK_CK: begin
                if (!due) begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_TICK_RD;
                end else if (!pend_valid_reg || can_emit) begin
                    if (pend_valid_reg) begin
                        emit     = 1'b1;
                        out_item = '{status: STAT_FIRED, fired_handle: pend_handle_reg,
                                     last: 1'b0};
                    end
                    pend_valid_next  = 1'b1;
                    pend_handle_next = rd_owner;
                    cnt_next         = cnt_reg + 1'b1;
                    if (rd_rep != '0) begin
                        div_start  = 1'b1;
                        state_next = ST_TICK_DIV;
                    end else begin
                        used_next[idx] = 1'b0;
                        idx_next       = idx_reg + 1'b1;
                        state_next     = ST_TICK_RD;
                    end
                end
            end
            ST_TICK_DIV: begin
                if (div_done) begin
                    ram_we     = 1'b1;
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_TICK_RD;
                end
            end
            ST_TICK_END: begin
                if (can_emit) begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                    if (pend_valid_reg) begin
                        out_item = '{status: STAT_FIRED, fired_handle: pend_handle_reg,
                                     last: 1'b1};
                    end else begin
                        out_item = '{status: STAT_NONE, fired_handle: '0, last: 1'b1};
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            used_reg       <= '0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            cnt_reg        <= '0;
            idx_reg        <= '0;
            free_found_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            pend_valid_reg <= pend_valid_next;
            cnt_reg        <= cnt_next;
            idx_reg        <= idx_next;
            free_found_reg <= free_found_next;
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
        free_idx_reg    <= free_idx_next;
        pend_handle_reg <= pend_handle_next;
        fire_reg        <= fire_next;
        if (emit) begin
            out_reg <= out_item;
        end
        if (accept) begin
            kind_reg <= s_data.kind;
            h_reg    <= hmap[s_data.alarm_handle];
            tv_reg   <= s_data.time_value[TB-1:0];
            per_reg  <= s_data.period[TB-1:0];
            now_reg  <= s_data.now[TB-1:0];
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> (!out_valid_reg || m_ready))
        else $error("result register overwritten while held");

    a_we_state: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == ST_PLACE || state_reg == ST_TICK_DIV))
        else $error("slot write outside place or advance");

    a_cnt_max: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_RESULTS))
        else $error("fired count beyond limit");

    a_div_rep: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TICK_DIV) |-> (rd_rep != '0))
        else $error("advance of a one-shot alarm");

endmodule

// ----- dv/alarm_table_scheduler_core_tb.sv -----
`timescale 1ns / 100ps
// alarm_table_scheduler_core_tb: self-checking testbench for the alarm table scheduler.
// Directed table, a fill and overflow run, then random sets, cancels and ticks against an in-bench predictor.
// Depends on ats_pkg and alarm_table_scheduler_core.
module alarm_table_scheduler_core_tb
    import ats_pkg::*;
;

    localparam int SLOTS = 64;
    localparam int IN_W  = $bits(in_item_t);
    localparam logic [61:0] TMAX = {62{1'b1}};

    typedef struct packed {
        logic        chk;
        in_item_t    item;
        out_item_t   res;
    } dir_row_t;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    int s_idle_pct = 34;
    int m_idle_pct = 52;
    int n_fail = 0;

    bit          tbl_used  [SLOTS];
    logic [7:0]  tbl_owner [SLOTS];
    logic [62:0] tbl_fire  [SLOTS];
    logic [61:0] tbl_rep   [SLOTS];
    logic [7:0]  live_hnd  [$];

    out_item_t exp_results [$];
    dir_row_t  dir_rows    [$];

    alarm_table_scheduler_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    initial begin
        #20000000;
        $display("alarm_table_scheduler_core_tb NOT OK");
        $finish;
    end

    function automatic logic [62:0] next_after(logic [62:0] base, logic [61:0] now_t,
                                               logic [61:0] per);
        logic [62:0] steps;
        begin
            steps = ({1'b0, now_t} - base) / {1'b0, per} + 63'd1;
            return base + steps * {1'b0, per};
        end
    endfunction

    function automatic void drop_owner(logic [7:0] h);
        for (int i = 0; i < SLOTS; i++)
            if (tbl_used[i] && tbl_owner[i] == h) tbl_used[i] = 0;
    endfunction

    function automatic status_t store_alarm(logic [7:0] h, logic [62:0] f, logic [61:0] r);
        drop_owner(h);
        for (int i = 0; i < SLOTS; i++)
            if (!tbl_used[i]) begin
                tbl_used[i] = 1; tbl_owner[i] = h; tbl_fire[i] = f; tbl_rep[i] = r;
                return STAT_OK;
            end
        return STAT_FULL;
    endfunction

    function automatic void predict_alarms(in_item_t it);
        out_item_t   r;
        logic [62:0] start;
        int          n;
        begin
            r = '0;
            r.last = 1'b1;
            n = 0;
            case (it.kind)
                KIND_SET_ONE: r.status = store_alarm(it.alarm_handle,
                                  {1'b0, it.now} + {1'b0, it.time_value}, '0);
                KIND_SET_PER: begin
                    if (it.period == 0) begin
                        r.status = STAT_BAD_PERIOD;
                    end else begin
                        start = {1'b0, it.time_value};
                        if (it.time_value < it.now)
                            start = next_after(start, it.now, it.period);
                        r.status = store_alarm(it.alarm_handle, start, it.period);
                    end
                end
                KIND_CANCEL: begin
                    drop_owner(it.alarm_handle);
                    r.status = STAT_OK;
                end
                default: begin
                    for (int i = 0; i < SLOTS && n < MAX_RESULTS; i++) begin
                        if (!tbl_used[i] || tbl_fire[i] > {1'b0, it.now}) continue;
                        exp_results.push_back('{STAT_FIRED, tbl_owner[i], 1'b0});
                        n++;
                        if (tbl_rep[i] != 0)
                            tbl_fire[i] = next_after(tbl_fire[i], it.now, tbl_rep[i]);
                        else
                            tbl_used[i] = 0;
                    end
                    if (n > 0) exp_results[$].last = 1'b1;
                    else r.status = STAT_NONE;
                end
            endcase
            if (n == 0) exp_results.push_back(r);
        end
    endfunction

    task automatic send_item(in_item_t it);
        if ($urandom_range(99) < s_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < s_idle_pct) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk iff s_ready);
        predict_alarms(it);
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (exp_results.size() == 0) begin
                    n_fail++;
                    if (n_fail <= 10) $display("unexpected transfer %p", m_data);
                end else begin
                    if (m_data !== exp_results[0]) begin
                        n_fail++;
                        if (n_fail <= 10)
                            $display("mismatch exp %p got %p", exp_results[0], m_data);
                    end
                    void'(exp_results.pop_front());
                end
            end
            m_ready <= ($urandom_range(99) >= m_idle_pct);
        end
    end

    function automatic in_item_t rand_item();
        in_item_t    it;
        int          sel;
        logic [61:0] base_now;
        begin
            it = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom});
            sel = $urandom_range(99);
            base_now = {52'd0, 10'($urandom_range(1023))};
            it.now = ($urandom_range(9) == 0) ? it.now : base_now;
            if (live_hnd.size() > 0 && $urandom_range(1))
                it.alarm_handle = live_hnd[$urandom_range(live_hnd.size() - 1)];
            if (sel < 30) begin
                it.kind = KIND_SET_ONE;
                if ($urandom_range(3) != 0) it.time_value = 62'($urandom_range(300));
            end else if (sel < 55) begin
                it.kind = KIND_SET_PER;
                if ($urandom_range(3) != 0) begin
                    it.time_value = 62'($urandom_range(1200));
                    it.period = 62'($urandom_range(200));
                end
            end else if (sel < 65) begin
                it.kind = KIND_CANCEL;
            end else begin
                it.kind = KIND_TICK;
            end
            if (it.kind != KIND_TICK) live_hnd.push_back(it.alarm_handle);
            if (live_hnd.size() > 40) void'(live_hnd.pop_front());
            return it;
        end
    endfunction

    initial begin
        in_item_t it;
        dir_row_t row;
        int       phase;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        dir_rows.push_back('{1, '{KIND_TICK, 8'd0, 62'd0, 62'd0, 62'd0},
                           '{STAT_NONE, 8'd0, 1'b1}});
        dir_rows.push_back('{1, '{KIND_CANCEL, 8'hFF, TMAX, TMAX, TMAX},
                           '{STAT_OK, 8'd0, 1'b1}});
        dir_rows.push_back('{1, '{KIND_SET_PER, 8'h12, 62'd5, 62'd0, 62'd9},
                           '{STAT_BAD_PERIOD, 8'd0, 1'b1}});
        dir_rows.push_back('{1, '{KIND_SET_ONE, 8'hFF, TMAX, TMAX, TMAX},
                           '{STAT_OK, 8'd0, 1'b1}});
        dir_rows.push_back('{1, '{KIND_SET_PER, 8'h00, 62'd0, TMAX, TMAX},
                           '{STAT_OK, 8'd0, 1'b1}});
        dir_rows.push_back('{0, '{KIND_SET_PER, 8'h01, 62'd3, 62'd7, 62'd100}, '0});
        dir_rows.push_back('{0, '{KIND_SET_ONE, 8'h02, 62'd0, 62'd0, 62'd50}, '0});
        dir_rows.push_back('{0, '{KIND_TICK, 8'h00, 62'd0, 62'd0, 62'd120}, '0});
        dir_rows.push_back('{0, '{KIND_SET_ONE, 8'h01, 62'd10, 62'd0, 62'd120}, '0});
        dir_rows.push_back('{0, '{KIND_TICK, 8'h00, 62'd0, 62'd0, TMAX}, '0});
        dir_rows.push_back('{0, '{KIND_CANCEL, 8'h00, 62'd0, 62'd0, 62'd0}, '0});
        dir_rows.push_back('{0, '{KIND_TICK, 8'h00, 62'd0, 62'd0, TMAX}, '0});

        foreach (dir_rows[k]) begin
            row = dir_rows[k];
            send_item(row.item);
            if (row.chk && exp_results[$] !== row.res) begin
                n_fail++;
                if (n_fail <= 10) $display("table row %0d predicted %p", k, exp_results[$]);
            end
        end

        // fill the table, overflow it, then fire all at once
        for (int i = 0; i < SLOTS + 1; i++) begin
            it = '{KIND_SET_ONE, 8'(i + 16), 62'(i), 62'd0, 62'd0};
            send_item(it);
        end
        send_item('{KIND_TICK, 8'd0, 62'd0, 62'd0, 62'd1000});

        for (phase = 0; phase < 3; phase++) begin
            s_idle_pct = (phase == 0) ? 34 : (phase == 1) ? 52 : 0;
            m_idle_pct = (phase == 0) ? 52 : (phase == 1) ? 34 : 0;
            for (int j = 0; j < 8; j++) send_item(rand_item());
        end
        send_item('{KIND_TICK, 8'd0, 62'd0, 62'd0, TMAX});
        s_valid <= 1'b0;

        while (exp_results.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (n_fail == 0 && exp_results.size() == 0)
            $display("alarm_table_scheduler_core_tb OK");
        else
            $display("alarm_table_scheduler_core_tb NOT OK");
        $finish;
    end
endmodule
